[hw/rtl/hsl2rgb_pkg.sv]
// Shared types, constants and helpers for the HSL to RGB converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hsl2rgb_pkg;

  // Width of one output color channel.
  localparam int CH_W = 8;

  // Hue sector, floor(6 * hue): which channel carries chroma, X or zero.
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,  // red chroma, green X
    SECT_YG = 3'd1,  // green chroma, red X
    SECT_GC = 3'd2,  // green chroma, blue X
    SECT_CB = 3'd3,  // blue chroma, green X
    SECT_BM = 3'd4,  // blue chroma, red X
    SECT_MR = 3'd5   // red chroma, blue X
  } sector_t;

  // Clip a channel that reached exactly 1.0 (256) to full scale.
  function automatic logic [CH_W-1:0] sat_chan(input logic [CH_W:0] v);
    sat_chan = v[CH_W] ? {CH_W{1'b1}} : v[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hsl2rgb_ifs.sv]
// Handshake channel interfaces of the HSL to RGB converter.
// Depends on hsl2rgb_pkg for the channel width.
`default_nettype none

interface hsl2rgb_hsl_if #(
  parameter int FRAC_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   lightness;

  modport source  (output valid, hue, saturation, lightness, input ready);
  modport sink    (input valid, hue, saturation, lightness, output ready);
  modport monitor (input valid, ready, hue, saturation, lightness);
endinterface

interface hsl2rgb_rgb_if
  import hsl2rgb_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source  (output valid, red, green, blue, input ready);
  modport sink    (input valid, red, green, blue, output ready);
  modport monitor (input valid, ready, red, green, blue);
endinterface

`default_nettype wire

[hw/rtl/hsl2rgb_front.sv]
// Stage 1: clamp inputs, form 1 - |2L - 1| and the hue sector and triangle factor.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_front
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  wire  [FRAC_BITS-1:0] hue,
  input  wire  [FRAC_BITS:0]   saturation,
  input  wire  [FRAC_BITS:0]   lightness,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output logic [FRAC_BITS:0]   om_dist,
  output logic [FRAC_BITS:0]   sat_c,
  output logic [FRAC_BITS:0]   light_c,
  output sector_t              sector,
  output logic [FRAC_BITS:0]   factor
);

  localparam logic [FRAC_BITS:0]   ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] ONE2 = {2'b01, {FRAC_BITS{1'b0}}};

  logic                 valid_r;
  logic [FRAC_BITS:0]   om_r, sat_r, light_r, factor_r;
  sector_t              sector_r;

  logic [FRAC_BITS:0]   s_c, l_c, tdist, om_nxt, factor_nxt;
  logic [FRAC_BITS+1:0] twol, ldev;
  logic [FRAC_BITS+2:0] h6;
  logic [FRAC_BITS:0]   t;

  always_comb begin
    s_c  = (saturation > ONE) ? ONE : saturation;
    l_c  = (lightness > ONE) ? ONE : lightness;
    twol = {l_c, 1'b0};
    ldev = (twol >= ONE2) ? (twol - ONE2) : (ONE2 - twol);
    om_nxt = ONE - ldev[FRAC_BITS:0];
    // 6 * hue as 4h + 2h; sector is the integer part, t the part mod 2.
    h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    t  = h6[FRAC_BITS:0];
    tdist = (t >= ONE) ? (t - ONE) : (ONE - t);
    factor_nxt = ONE - tdist;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      om_r     <= om_nxt;
      sat_r    <= s_c;
      light_r  <= l_c;
      sector_r <= sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
      factor_r <= factor_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign om_dist  = om_r;
  assign sat_c    = sat_r;
  assign light_c  = light_r;
  assign sector   = sector_r;
  assign factor   = factor_r;

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_chroma.sv]
// Stages 2 and 3: chroma product, then X product with the m and chroma + m sums.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_chroma
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    up_valid,
  output logic                   up_ready,
  input  wire  [FRAC_BITS:0]     om_dist,
  input  wire  [FRAC_BITS:0]     sat_c,
  input  wire  [FRAC_BITS:0]     light_c,
  input  sector_t                sector,
  input  wire  [FRAC_BITS:0]     factor,
  output logic                   dn_valid,
  input  wire                    dn_ready,
  output logic [3*FRAC_BITS:0]   xprod,
  output logic [2*FRAC_BITS+1:0] cplus,
  output logic [2*FRAC_BITS+1:0] mval,
  output sector_t                sector_o
);

  // Stage 2 registers
  logic                   v2_r;
  logic [2*FRAC_BITS:0]   cn_r;
  logic [FRAC_BITS:0]     l2_r, f2_r;
  sector_t                sec2_r;
  logic                   rdy2;

  // Stage 3 registers
  logic                   v3_r;
  logic [3*FRAC_BITS:0]   xp_r;
  logic [2*FRAC_BITS+1:0] cp_r, mv_r;
  sector_t                sec3_r;
  logic                   rdy3;

  logic [2*FRAC_BITS+1:0] cn_full;
  logic [3*FRAC_BITS+1:0] xp_full;
  logic [2*FRAC_BITS+1:0] lsh, cn_ext;

  // chroma over one^2: (1 - |2L - 1|) * S, never above one^2
  assign cn_full = om_dist * sat_c;

  // X over one^3 takes cn * factor; m and chroma + m over 2*one^2
  assign xp_full = cn_r * f2_r;
  assign lsh     = {l2_r, {(FRAC_BITS + 1){1'b0}}};
  assign cn_ext  = {1'b0, cn_r};

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign up_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= up_valid;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && up_valid) begin
      cn_r   <= cn_full[2*FRAC_BITS:0];
      l2_r   <= light_c;
      f2_r   <= factor;
      sec2_r <= sector;
    end
    if (rdy3 && v2_r) begin
      xp_r   <= xp_full[3*FRAC_BITS:0];
      cp_r   <= lsh + cn_ext;
      mv_r   <= lsh - cn_ext;
      sec3_r <= sec2_r;
    end
  end

  assign dn_valid = v3_r;
  assign xprod    = xp_r;
  assign cplus    = cp_r;
  assign mval     = mv_r;
  assign sector_o = sec3_r;

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_out.sv]
// Stage 4: scale chroma, X and zero plus m to bytes, clip, place by sector.
// Depends on hsl2rgb_pkg for sector codes and the clip helper.
`default_nettype none

module hsl2rgb_out
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    up_valid,
  output logic                   up_ready,
  input  wire  [3*FRAC_BITS:0]   xprod,
  input  wire  [2*FRAC_BITS+1:0] cplus,
  input  wire  [2*FRAC_BITS+1:0] mval,
  input  sector_t                sector,
  output logic                   dn_valid,
  input  wire                    dn_ready,
  output logic [CH_W-1:0]        red,
  output logic [CH_W-1:0]        green,
  output logic [CH_W-1:0]        blue
);

  logic                   valid_r;
  logic [CH_W-1:0]        red_r, green_r, blue_r;
  logic [CH_W-1:0]        red_nxt, green_nxt, blue_nxt;
  logic [3*FRAC_BITS+1:0] xsum;
  logic [CH_W-1:0]        c_ch, x_ch, m_ch;

  always_comb begin
    xsum = {xprod, 1'b0} + {mval, {FRAC_BITS{1'b0}}};
    c_ch = sat_chan(cplus[2*FRAC_BITS+1 -: CH_W+1]);
    m_ch = sat_chan(mval[2*FRAC_BITS+1 -: CH_W+1]);
    x_ch = sat_chan(xsum[3*FRAC_BITS+1 -: CH_W+1]);
    case (sector)
      SECT_RY: begin red_nxt = c_ch; green_nxt = x_ch; blue_nxt = m_ch; end
      SECT_YG: begin red_nxt = x_ch; green_nxt = c_ch; blue_nxt = m_ch; end
      SECT_GC: begin red_nxt = m_ch; green_nxt = c_ch; blue_nxt = x_ch; end
      SECT_CB: begin red_nxt = m_ch; green_nxt = x_ch; blue_nxt = c_ch; end
      SECT_BM: begin red_nxt = x_ch; green_nxt = m_ch; blue_nxt = c_ch; end
      default: begin red_nxt = c_ch; green_nxt = m_ch; blue_nxt = x_ch; end
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

endmodule

`default_nettype wire

[hw/rtl/hsl_to_rgb_converter_core.sv]
// HSL to RGB converter top level: four-stage pipeline, one item per clock while the output is not stalled.
// The two multipliers are each one stage.
// Reset (rst_n low, synchronous) clears every stage valid bit; data holds.
// Depends on hsl2rgb_pkg, hsl2rgb_ifs, hsl2rgb_front, hsl2rgb_chroma, hsl2rgb_out.
`default_nettype none

module hsl_to_rgb_converter_core
  import hsl2rgb_pkg::*;
#(
  // Fraction bits of hue, saturation and lightness (8 to 16).
  parameter int FRAC_BITS = 12
) (
  input wire                  clk,
  input wire                  rst_n,
  hsl2rgb_hsl_if.sink         in_pix,
  hsl2rgb_rgb_if.source       out_pix
);

  // Stage 1 -> stage 2
  logic                   s1_valid, s1_ready;
  logic [FRAC_BITS:0]     s1_om, s1_sat, s1_light, s1_factor;
  sector_t                s1_sector;

  // Stage 3 -> stage 4
  logic                   s3_valid, s3_ready;
  logic [3*FRAC_BITS:0]   s3_xprod;
  logic [2*FRAC_BITS+1:0] s3_cplus, s3_mval;
  sector_t                s3_sector;

  // Stage 1: clamp saturation and lightness to 1.0, wrap hue to one turn,
  // and split 6 * hue into its sector and the triangle factor 1 - |H' mod 2 - 1|.
  hsl2rgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_pix.valid),
    .up_ready   (in_pix.ready),
    .hue        (in_pix.hue),
    .saturation (in_pix.saturation),
    .lightness  (in_pix.lightness),
    .dn_valid   (s1_valid),
    .dn_ready   (s1_ready),
    .om_dist    (s1_om),
    .sat_c      (s1_sat),
    .light_c    (s1_light),
    .sector     (s1_sector),
    .factor     (s1_factor)
  );

  // Stages 2 and 3: chroma = (1 - |2L - 1|) * S, then chroma * factor for X.
  // All terms are kept exact; nothing is rounded before the final shift.
  hsl2rgb_chroma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .om_dist  (s1_om),
    .sat_c    (s1_sat),
    .light_c  (s1_light),
    .sector   (s1_sector),
    .factor   (s1_factor),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .xprod    (s3_xprod),
    .cplus    (s3_cplus),
    .mval     (s3_mval),
    .sector_o (s3_sector)
  );

  // Stage 4: truncate each of chroma + m, X + m and m to a byte, clip 1.0 to
  // full scale, and route them to red, green and blue by sector. This stage
  // is also the output register, so a stalled result never blocks new input
  // while an earlier stage has room.
  hsl2rgb_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .xprod    (s3_xprod),
    .cplus    (s3_cplus),
    .mval     (s3_mval),
    .sector   (s3_sector),
    .dn_valid (out_pix.valid),
    .dn_ready (out_pix.ready),
    .red      (out_pix.red),
    .green    (out_pix.green),
    .blue     (out_pix.blue)
  );

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_chk.sv]
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends on hsl2rgb_pkg for the channel width.
`default_nettype none

module hsl2rgb_chk
  import hsl2rgb_pkg::*;
(
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input wire [CH_W-1:0] out_red,
  input wire [CH_W-1:0] out_green,
  input wire [CH_W-1:0] out_blue
);

  localparam logic [2:0] PIPE_DEPTH = 3'd4;

  logic [2:0] inflight_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track items accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_r + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  // A result held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue))
    else $error("stalled result changed");

  // Input is refused only when every stage is full and the output is stalled.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && inflight_r == PIPE_DEPTH)
    else $error("input refused with room in the pipeline");

  // No result appears without an item in flight.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result without an accepted item");

  // Never more items in flight than pipeline stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= PIPE_DEPTH)
    else $error("more items in flight than stages");

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.red),
  .out_green (out_pix.green),
  .out_blue  (out_pix.blue)
);

`default_nettype wire
